[design/iovc_pkg.sv]
`timescale 1ns / 1ps

package iovc_pkg;

  localparam int unsigned MaxResults = 16;
  localparam int unsigned ResCntW = $clog2(MaxResults + 1);

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_CHROM_ORD = 2'd1,
    ERR_ACT_OVF   = 2'd2,
    ERR_TBL_FULL  = 2'd3
  } err_e;

  typedef enum logic {
    CMD_PEAK = 1'b0,
    CMD_FRAG = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic        command;
    logic [11:0] chrom;
    logic [30:0] coord_start;
    logic [30:0] coord_end;
    logic [23:0] cell_req;
    logic [11:0] column;
  } in_beat_t;

  typedef struct packed {
    logic [11:0] peak_column;
    logic [23:0] cell_id;
    logic [1:0]  overlap_count;
    logic        last;
    logic [1:0]  error;
  } out_beat_t;

  typedef struct packed {
    logic [11:0] chrom;
    logic [30:0] pstart;
    logic [30:0] pend;
    logic [11:0] column;
  } peak_t;

endpackage

[design/iovc_if.sv]
`timescale 1ns / 1ps

interface iovc_in_if;
  logic               valid;
  logic               ready;
  iovc_pkg::in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface iovc_out_if;
  logic                valid;
  logic                ready;
  iovc_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/iovc_ram.sv]
`timescale 1ns / 1ps

module iovc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[design/interval_overlap_counter.sv]
`timescale 1ns / 1ps

// Sweep-line overlap counter. Peak beats (command 0) are appended to a peak
// table without leaving idle; fragment beats (command 1) are then processed by
// a small sequencer around the single-port-read peak table. Each table lookup
// is a read state (address) followed by a check state (compare). After a
// fragment is accepted the input stays not ready while the sequencer scans for
// peaks to activate, walks the active peaks and flushes the held result, also
// while it waits on a full output register. A chromosome-order or table-full
// error holds the input until its error result has gone to the output register.
// Results are produced one per beat, the final one of each fragment marked
// with last.
module interval_overlap_counter #(
  parameter int unsigned MAX_PEAKS  = 4096,
  parameter int unsigned MAX_ACTIVE = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  iovc_in_if.sink    in_i,
  iovc_out_if.source out_o
);

  localparam int unsigned AW = $clog2(MAX_PEAKS);
  localparam int unsigned PW = $clog2(MAX_PEAKS + 1);
  localparam int unsigned SW = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1;
  localparam int unsigned CW = $clog2(MAX_ACTIVE + 1);
  localparam int unsigned RW = iovc_pkg::ResCntW;

  iovc_pkg::state_e state_q, state_d;
  logic [PW-1:0] peak_total_q, peak_total_d;
  logic [PW-1:0] nta_q, nta_d;
  logic [CW-1:0] at_q, at_d;
  logic [CW-1:0] j_q, j_d;
  logic [CW-1:0] kept_q, kept_d;
  logic [RW-1:0] n_q, n_d;
  logic [11:0]   cur_chrom_q, cur_chrom_d;
  logic [30:0]   rem_q, rem_d;
  logic          skip_q, skip_d;
  logic [AW-1:0] slots_q [MAX_ACTIVE];
  logic [AW-1:0] cur_idx_q, cur_idx_d;
  logic [30:0]   fs_q, fs_d, fe_q, fe_d;
  logic [23:0]   cell_q, cell_d;
  logic          pend_vld_q, pend_vld_d;
  iovc_pkg::out_beat_t pend_q, pend_d;
  logic          out_vld_q, out_vld_d;
  iovc_pkg::out_beat_t out_q, out_d;

  logic          slot_we;
  logic [SW-1:0] slot_waddr;
  logic          tbl_we, tbl_re;
  logic [AW-1:0] tbl_raddr;
  iovc_pkg::peak_t tbl_wdata, tbl_rdata;
  logic          out_free;
  logic          st_in, en_in;
  logic [1:0]    cnt;

  assign tbl_wdata = '{chrom: in_i.data.chrom, pstart: in_i.data.coord_start,
                       pend: in_i.data.coord_end, column: in_i.data.column};

  iovc_ram #(
    .Width($bits(iovc_pkg::peak_t)),
    .Depth(MAX_PEAKS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(peak_total_q[AW-1:0]),
    .wdata_i(tbl_wdata),
    .re_i   (tbl_re),
    .raddr_i(tbl_raddr),
    .rdata_o(tbl_rdata)
  );

  assign out_free = !out_vld_q || out_o.ready;
  assign st_in = (fs_q >= tbl_rdata.pstart) && (fs_q < tbl_rdata.pend);
  assign en_in = (fe_q > tbl_rdata.pstart) && (fe_q <= tbl_rdata.pend);
  assign cnt = {1'b0, st_in} + {1'b0, en_in};

  assign in_i.ready = (state_q == iovc_pkg::ST_IDLE);
  assign out_o.valid = out_vld_q;
  assign out_o.data = out_q;

  always_comb begin
    state_d      = state_q;
    peak_total_d = peak_total_q;
    nta_d        = nta_q;
    at_d         = at_q;
    j_d          = j_q;
    kept_d       = kept_q;
    n_d          = n_q;
    cur_chrom_d  = cur_chrom_q;
    rem_d        = rem_q;
    skip_d       = skip_q;
    cur_idx_d    = cur_idx_q;
    fs_d         = fs_q;
    fe_d         = fe_q;
    cell_d       = cell_q;
    pend_vld_d   = pend_vld_q;
    pend_d       = pend_q;
    out_vld_d    = out_vld_q && !out_o.ready;
    out_d        = out_q;
    slot_we      = 1'b0;
    slot_waddr   = kept_q[SW-1:0];
    tbl_we       = 1'b0;
    tbl_re       = 1'b0;
    tbl_raddr    = nta_q[AW-1:0];

    case (state_q)
      iovc_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          if (in_i.data.command == iovc_pkg::CMD_PEAK) begin
            if (peak_total_q >= PW'(MAX_PEAKS)) begin
              pend_vld_d = 1'b1;
              pend_d = '{peak_column: in_i.data.column, cell_id: '0,
                         overlap_count: '0, last: 1'b1,
                         error: iovc_pkg::ERR_TBL_FULL};
              state_d = iovc_pkg::ST_FLUSH;
            end else begin
              tbl_we = 1'b1;
              peak_total_d = peak_total_q + 1'b1;
            end
          end else begin
            fs_d   = in_i.data.coord_start;
            fe_d   = in_i.data.coord_end;
            cell_d = in_i.data.cell_req;
            n_d    = '0;
            if (in_i.data.chrom < cur_chrom_q) begin
              pend_vld_d = 1'b1;
              pend_d = '{peak_column: '0, cell_id: in_i.data.cell_req,
                         overlap_count: '0, last: 1'b1,
                         error: iovc_pkg::ERR_CHROM_ORD};
              state_d = iovc_pkg::ST_FLUSH;
            end else begin
              if (in_i.data.chrom > cur_chrom_q) begin
                cur_chrom_d = in_i.data.chrom;
                at_d = '0;
                rem_d = in_i.data.coord_end;
                skip_d = 1'b1;
              end else if (in_i.data.coord_end > rem_q) begin
                rem_d = in_i.data.coord_end;
              end
              state_d = iovc_pkg::ST_SCAN_RD;
            end
          end
        end
      end

      iovc_pkg::ST_SCAN_RD: begin
        if (nta_q < peak_total_q) begin
          tbl_re = 1'b1;
          state_d = iovc_pkg::ST_SCAN_CHK;
        end else begin
          skip_d = 1'b0;
          j_d = '0;
          kept_d = '0;
          state_d = iovc_pkg::ST_WALK_RD;
        end
      end

      iovc_pkg::ST_SCAN_CHK: begin
        if (skip_q && tbl_rdata.chrom < cur_chrom_q) begin
          nta_d = nta_q + 1'b1;
          state_d = iovc_pkg::ST_SCAN_RD;
        end else if (tbl_rdata.chrom == cur_chrom_q && tbl_rdata.pstart < rem_q) begin
          skip_d = 1'b0;
          nta_d = nta_q + 1'b1;
          if (at_q >= CW'(MAX_ACTIVE)) begin
            // The overflowing peak is dropped and the fragment stops here.
            pend_vld_d = 1'b1;
            pend_d = '{peak_column: '0, cell_id: cell_q, overlap_count: '0,
                       last: 1'b1, error: iovc_pkg::ERR_ACT_OVF};
            state_d = iovc_pkg::ST_FLUSH;
          end else begin
            slot_we = 1'b1;
            slot_waddr = at_q[SW-1:0];
            at_d = at_q + 1'b1;
            state_d = iovc_pkg::ST_SCAN_RD;
          end
        end else begin
          skip_d = 1'b0;
          j_d = '0;
          kept_d = '0;
          state_d = iovc_pkg::ST_WALK_RD;
        end
      end

      iovc_pkg::ST_WALK_RD: begin
        if (j_q < at_q) begin
          tbl_re = 1'b1;
          tbl_raddr = slots_q[j_q[SW-1:0]];
          cur_idx_d = slots_q[j_q[SW-1:0]];
          state_d = iovc_pkg::ST_WALK_CHK;
        end else begin
          at_d = kept_q;
          state_d = iovc_pkg::ST_FLUSH;
        end
      end

      iovc_pkg::ST_WALK_CHK: begin
        if (fs_q >= tbl_rdata.pend) begin
          j_d = j_q + 1'b1;
          state_d = iovc_pkg::ST_WALK_RD;
        end else if (cnt != 2'd0 && n_q < RW'(iovc_pkg::MaxResults)) begin
          // The previous result leaves only once a later one proves it is not last.
          if (!pend_vld_q || out_free) begin
            if (pend_vld_q) begin
              out_vld_d = 1'b1;
              out_d = pend_q;
            end
            pend_vld_d = 1'b1;
            pend_d = '{peak_column: tbl_rdata.column, cell_id: cell_q,
                       overlap_count: cnt, last: 1'b0, error: iovc_pkg::ERR_NONE};
            n_d = n_q + 1'b1;
            slot_we = 1'b1;
            kept_d = kept_q + 1'b1;
            j_d = j_q + 1'b1;
            state_d = iovc_pkg::ST_WALK_RD;
          end
        end else begin
          slot_we = 1'b1;
          kept_d = kept_q + 1'b1;
          j_d = j_q + 1'b1;
          state_d = iovc_pkg::ST_WALK_RD;
        end
      end

      iovc_pkg::ST_FLUSH: begin
        if (!pend_vld_q) begin
          state_d = iovc_pkg::ST_IDLE;
        end else if (out_free) begin
          out_vld_d = 1'b1;
          out_d = pend_q;
          out_d.last = 1'b1;
          pend_vld_d = 1'b0;
          state_d = iovc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = iovc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= iovc_pkg::ST_IDLE;
      peak_total_q <= '0;
      nta_q        <= '0;
      at_q         <= '0;
      j_q          <= '0;
      kept_q       <= '0;
      n_q          <= '0;
      cur_chrom_q  <= '0;
      rem_q        <= '0;
      skip_q       <= 1'b0;
      pend_vld_q   <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      peak_total_q <= peak_total_d;
      nta_q        <= nta_d;
      at_q         <= at_d;
      j_q          <= j_d;
      kept_q       <= kept_d;
      n_q          <= n_d;
      cur_chrom_q  <= cur_chrom_d;
      rem_q        <= rem_d;
      skip_q       <= skip_d;
      pend_vld_q   <= pend_vld_d;
      out_vld_q    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_idx_q <= cur_idx_d;
    fs_q      <= fs_d;
    fe_q      <= fe_d;
    cell_q    <= cell_d;
    pend_q    <= pend_d;
    out_q     <= out_d;
    if (slot_we) begin
      slots_q[slot_waddr] <= (state_q == iovc_pkg::ST_SCAN_CHK) ? nta_q[AW-1:0] : cur_idx_q;
    end
  end

  a_active_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    at_q <= CW'(MAX_ACTIVE))
    else $error("active count above capacity");

  a_nta_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nta_q <= peak_total_q)
    else $error("activation pointer passed table fill");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == iovc_pkg::ST_IDLE |-> !pend_vld_q)
    else $error("held result left behind in idle");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.error != iovc_pkg::ERR_NONE |->
      out_q.last && out_q.overlap_count == 2'd0)
    else $error("error beat malformed");

endmodule

[tb/interval_overlap_counter_test.sv]
`timescale 1ns / 1ps

module interval_overlap_counter_test;

  localparam int unsigned NPeaks = 4096;
  localparam int unsigned NActive = 16;
  localparam longint unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  iovc_in_if  in_ch ();
  iovc_out_if out_ch ();

  interval_overlap_counter #(.MAX_PEAKS(NPeaks), .MAX_ACTIVE(NActive)) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the peak table and sweep state.
  iovc_pkg::peak_t peak_tab [NPeaks];
  int unsigned peak_cnt;
  int unsigned activate_ptr;
  int unsigned live_idx [NActive];
  int unsigned live_cnt;
  logic [11:0] sweep_chrom;
  logic [30:0] reach_max;

  iovc_pkg::out_beat_t pending_q [$];
  int          fail_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  longint unsigned cycle_cnt;

  function automatic iovc_pkg::out_beat_t mk_res(logic [11:0] col, logic [23:0] cid,
                                                 logic [1:0] cnt, logic lst,
                                                 iovc_pkg::err_e err);
    iovc_pkg::out_beat_t r;
    r.peak_column = col;
    r.cell_id = cid;
    r.overlap_count = cnt;
    r.last = lst;
    r.error = err;
    return r;
  endfunction

  task automatic predict_overlaps(input iovc_pkg::in_beat_t b);
    iovc_pkg::out_beat_t res [$];
    int unsigned kept;
    int unsigned idx;
    logic [1:0]  cnt;
    if (b.command == iovc_pkg::CMD_PEAK) begin
      if (peak_cnt >= NPeaks) begin
        pending_q = {pending_q, mk_res(b.column, '0, 2'd0, 1'b1, iovc_pkg::ERR_TBL_FULL)};
      end else begin
        peak_tab[peak_cnt] = '{b.chrom, b.coord_start, b.coord_end, b.column};
        peak_cnt++;
      end
      return;
    end
    if (b.chrom < sweep_chrom) begin
      pending_q = {pending_q, mk_res('0, b.cell_req, 2'd0, 1'b1, iovc_pkg::ERR_CHROM_ORD)};
      return;
    end
    if (b.chrom > sweep_chrom) begin
      sweep_chrom = b.chrom;
      live_cnt = 0;
      reach_max = '0;
      while (activate_ptr < peak_cnt && peak_tab[activate_ptr].chrom < b.chrom)
        activate_ptr++;
    end
    if (b.coord_end > reach_max) reach_max = b.coord_end;
    while (activate_ptr < peak_cnt && peak_tab[activate_ptr].chrom == sweep_chrom &&
           peak_tab[activate_ptr].pstart < reach_max) begin
      if (live_cnt >= NActive) begin
        activate_ptr++;
        pending_q = {pending_q, mk_res('0, b.cell_req, 2'd0, 1'b1, iovc_pkg::ERR_ACT_OVF)};
        return;
      end
      live_idx[live_cnt++] = activate_ptr;
      activate_ptr++;
    end
    kept = 0;
    for (int unsigned j = 0; j < live_cnt; j++) begin
      idx = live_idx[j];
      if (b.coord_start >= peak_tab[idx].pend) continue;
      live_idx[kept++] = idx;
      cnt = 2'(b.coord_start >= peak_tab[idx].pstart && b.coord_start < peak_tab[idx].pend)
          + 2'(b.coord_end > peak_tab[idx].pstart && b.coord_end <= peak_tab[idx].pend);
      if (cnt != 0 && res.size() < iovc_pkg::MaxResults)
        res = {res, mk_res(peak_tab[idx].column, b.cell_req, cnt, 1'b0, iovc_pkg::ERR_NONE)};
    end
    live_cnt = kept;
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    pending_q = {pending_q, res};
  endtask

  // Directed rows; a typed-in expectation is checked on top of the predictor.
  typedef struct {
    iovc_pkg::in_beat_t  beat;
    logic                has_exp;
    iovc_pkg::out_beat_t exp;
  } dir_row_t;

  dir_row_t            dir_rows [$];
  iovc_pkg::out_beat_t typed_q [$];

  function automatic iovc_pkg::in_beat_t mk_in(iovc_pkg::cmd_e c, int unsigned ch,
                                               int unsigned s, int unsigned e,
                                               int unsigned cid, int unsigned col);
    iovc_pkg::in_beat_t b;
    b.command = c;
    b.chrom = 12'(ch);
    b.coord_start = 31'(s);
    b.coord_end = 31'(e);
    b.cell_req = 24'(cid);
    b.column = 12'(col);
    return b;
  endfunction

  task automatic add_row(iovc_pkg::in_beat_t b);
    dir_row_t r;
    r.beat = b;
    r.has_exp = 1'b0;
    r.exp = '0;
    dir_rows = {dir_rows, r};
  endtask

  task automatic add_row_exp(iovc_pkg::in_beat_t b, iovc_pkg::out_beat_t e);
    dir_row_t r;
    r.beat = b;
    r.has_exp = 1'b1;
    r.exp = e;
    dir_rows = {dir_rows, r};
  endtask

  // Valid stays up after a beat so that a following beat can go out without a
  // gap; it drops in the first idle cycle or in stop_input.
  task automatic send_beat(iovc_pkg::in_beat_t b);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_overlaps(b);
  endtask

  task automatic stop_input();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    iovc_pkg::out_beat_t want;
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end else if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (typed_q.size() > 0 && typed_q[0] !== out_ch.data) begin
        $display("%0t: directed result mismatch: expected %h, actual %h", $time,
                 typed_q[0], out_ch.data);
        fail_cnt++;
      end
      if (typed_q.size() > 0) void'(typed_q.pop_front());
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, out_ch.data);
        fail_cnt++;
      end else begin
        want = pending_q.pop_front();
        if (out_ch.data.peak_column !== want.peak_column)
          $display("%0t: peak_column: expected %0d, actual %0d", $time, want.peak_column,
                   out_ch.data.peak_column);
        if (out_ch.data.cell_id !== want.cell_id)
          $display("%0t: cell_id: expected %0d, actual %0d", $time, want.cell_id,
                   out_ch.data.cell_id);
        if (out_ch.data.overlap_count !== want.overlap_count)
          $display("%0t: overlap_count: expected %0d, actual %0d", $time, want.overlap_count,
                   out_ch.data.overlap_count);
        if (out_ch.data.last !== want.last)
          $display("%0t: last: expected %0d, actual %0d", $time, want.last, out_ch.data.last);
        if (out_ch.data.error !== want.error)
          $display("%0t: error: expected %0d, actual %0d", $time, want.error,
                   out_ch.data.error);
        if (out_ch.data !== want) fail_cnt++;
      end
    end
  end

  // A sorted set of peaks on one chromosome followed by fragments sweeping it.
  task automatic run_chrom_sweep(int unsigned ch, int unsigned npk, int unsigned nfr,
                                 int unsigned span);
    int unsigned pos;
    int unsigned len;
    pos = $urandom_range(span);
    for (int unsigned i = 0; i < npk; i++) begin
      pos += $urandom_range(span / 4);
      len = $urandom_range(span / 2) + 1;
      send_beat(mk_in(iovc_pkg::CMD_PEAK, ch, pos, pos + len, $urandom, $urandom));
    end
    pos = $urandom_range(span);
    for (int unsigned i = 0; i < nfr; i++) begin
      pos += $urandom_range(span / 3);
      send_beat(mk_in(iovc_pkg::CMD_FRAG, ch, pos, pos + $urandom_range(span), $urandom,
                      $urandom));
    end
  endtask

  initial begin
    iovc_pkg::in_beat_t b;
    int unsigned ch;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    fail_cnt = 0;
    cycle_cnt = 0;
    peak_cnt = 0;
    activate_ptr = 0;
    live_cnt = 0;
    sweep_chrom = '0;
    reach_max = '0;
    send_idle_pct = 26;
    recv_idle_pct = 54;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, overlap types, retirement, chromosome order, overflow.
    add_row(mk_in(iovc_pkg::CMD_FRAG, 0, 0, 10, 24'hFFFFFF, 0));
    add_row(mk_in(iovc_pkg::CMD_PEAK, 1, 100, 200, 0, 12'hFFF));
    add_row(mk_in(iovc_pkg::CMD_PEAK, 1, 150, 400, 0, 7));
    add_row(mk_in(iovc_pkg::CMD_FRAG, 1, 50, 150, 1, 0));
    add_row(mk_in(iovc_pkg::CMD_FRAG, 1, 120, 180, 2, 0));
    add_row(mk_in(iovc_pkg::CMD_FRAG, 1, 190, 500, 3, 0));
    add_row(mk_in(iovc_pkg::CMD_FRAG, 1, 200, 210, 4, 0));
    add_row(mk_in(iovc_pkg::CMD_FRAG, 1, 50, 600, 5, 0));
    add_row_exp(mk_in(iovc_pkg::CMD_FRAG, 0, 0, 1, 24'hABCDEF, 0),
                mk_res('0, 24'hABCDEF, 2'd0, 1'b1, iovc_pkg::ERR_CHROM_ORD));
    for (int unsigned i = 0; i < NActive + 1; i++)
      add_row(mk_in(iovc_pkg::CMD_PEAK, 2, i, 32'h7FFFFFFF, 0, i));
    add_row_exp(mk_in(iovc_pkg::CMD_FRAG, 2, 0, 32'h7FFFFFFF, 9, 0),
                mk_res('0, 24'd9, 2'd0, 1'b1, iovc_pkg::ERR_ACT_OVF));
    add_row(mk_in(iovc_pkg::CMD_FRAG, 2, 5, 32'h7FFFFFFF, 10, 0));
    foreach (dir_rows[i]) begin
      if (dir_rows[i].has_exp) begin
        // Earlier results drain first so the typed result lines up with its row.
        stop_input();
        while (pending_q.size() != 0) @(posedge clk_i);
        typed_q = {typed_q, dir_rows[i].exp};
      end
      send_beat(dir_rows[i].beat);
    end

    // Random: well-formed sweeps on increasing chromosomes, with some noise.
    ch = 3;
    for (int unsigned phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 54;
        recv_idle_pct = 26;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int unsigned k = 0; k < 3; k++) begin
        ch += $urandom_range(3) + 1;
        run_chrom_sweep(ch, $urandom_range(4) + 1, $urandom_range(4) + 2,
                        (k == 0) ? 32'h1FFFFFFF : 64);
        if ($urandom_range(1)) begin
          b = mk_in(iovc_pkg::CMD_FRAG, $urandom_range(ch), $urandom, $urandom, $urandom,
                    $urandom);
          send_beat(b);
        end
      end
    end
    ch = 12'hFFF;
    run_chrom_sweep(ch, 3, 4, 1000);

    // Extreme coordinates and chromosome ids at the top of the sweep.
    send_beat(mk_in(iovc_pkg::CMD_PEAK, 12'hFFF, 0, 0, 0, 12'hFFF));
    send_beat(mk_in(iovc_pkg::CMD_PEAK, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, $urandom, 12'h000));
    send_beat(mk_in(iovc_pkg::CMD_FRAG, 12'hFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 24'hFFFFFF, 0));
    stop_input();

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_cnt == 0 && pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
